// ===== hw/rtl/rpi_pkg.sv =====
// Shared types, constants and helpers for the point body integrator.
// Used by the controller, the datapath, the divider, the root unit and the top level.
package rpi_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RegW = 31;
  localparam int unsigned StepW = 17;
  localparam int unsigned FieldW = 32;
  localparam int unsigned AccW = 50;
  localparam int unsigned MagW = 50;
  localparam int unsigned SumW = 66;
  localparam int unsigned NumW = 64;
  localparam int unsigned DenW = 32;
  localparam int unsigned RootW = 32;
  localparam int unsigned Lanes = 3;

  localparam logic [RegW-1:0] MassReset = 31'd65536;
  localparam logic [RegW-1:0] LimitReset = 31'd655360;
  localparam logic [RegW-1:0] DragReset = 31'd0;
  // -9.81 in Q16.16
  localparam logic signed [AccW-1:0] GravityY = -50'sd642908;

  typedef logic [1:0] lane_t;
  localparam lane_t LaneLast = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BODY_MASS   = 3'd0,
    CFG_SPEED_LIMIT = 3'd1,
    CFG_DRAG_COEF   = 3'd2,
    CFG_GRAVITY_ON  = 3'd3,
    CFG_FRICTION_ON = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_PUSH,
    OP_SET_ACC,
    OP_GRAV,
    OP_MUL_VSQ,
    OP_ADD_PROD,
    OP_SQRT_START,
    OP_SET_VL,
    OP_MUL_VDRAG,
    OP_DIV_FRIC1,
    OP_DIV_FRIC2,
    OP_SUB_FRIC,
    OP_MUL_LO,
    OP_SUM_SET,
    OP_MUL_HI,
    OP_SET_MAG,
    OP_SHR,
    OP_CLR_SUM,
    OP_MUL_MSQ,
    OP_SET_LEN,
    OP_MUL_MSL,
    OP_DIV_CLAMP,
    OP_SET_MAGQ,
    OP_UPD_V,
    OP_UPD_P,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    lane_t  lane;
  } rpi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic root_zero;
    logic friction_on;
    logic too_big;
    logic clamp;
    logic out_stall;
  } rpi_stat_t;

  typedef struct packed {
    logic [StepW-1:0]         step_time;
    logic signed [FieldW-1:0] push_x;
    logic signed [FieldW-1:0] push_y;
    logic signed [FieldW-1:0] push_z;
  } rpi_in_t;

  typedef struct packed {
    logic signed [FieldW-1:0] vel_x;
    logic signed [FieldW-1:0] vel_y;
    logic signed [FieldW-1:0] vel_z;
    logic signed [FieldW-1:0] pos_x;
    logic signed [FieldW-1:0] pos_y;
    logic signed [FieldW-1:0] pos_z;
  } rpi_out_t;

  // Saturate a 33 bit signed sum to 32 bits
  function automatic logic signed [FieldW-1:0] sat33(input logic signed [FieldW:0] v);
    logic signed [FieldW-1:0] r;
    if (v[FieldW] != v[FieldW-1]) begin
      r = v[FieldW] ? {1'b1, {(FieldW-1){1'b0}}} : {1'b0, {(FieldW-1){1'b1}}};
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rpi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, truncating.
// Depends on rpi_pkg for operand widths.
module rpi_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rpi_pkg::NumW-1:0] num_i,
  input  logic [rpi_pkg::DenW-1:0] den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [rpi_pkg::NumW-1:0] quot_o
);
  import rpi_pkg::*;

  localparam int unsigned CntW = $clog2(NumW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quot_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [DenW:0]   trial, diff;
  logic            ge;

  assign trial = {rem_q, quot_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quot_q <= {quot_q[NumW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/rpi_sqrt.sv =====
// Floor square root of a 64 bit value, two radicand bits per cycle.
// Depends on rpi_pkg for widths.
module rpi_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rpi_pkg::NumW-1:0]  val_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [rpi_pkg::RootW-1:0] root_o
);
  import rpi_pkg::*;

  localparam int unsigned Steps = NumW / 2;
  localparam int unsigned CntW = $clog2(Steps);
  localparam logic [NumW-1:0] BitInit = {2'b01, {(NumW-2){1'b0}}};

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] n_q, r_q, bit_q, rb;
  logic            ge;

  assign rb = r_q + bit_q;
  assign ge = n_q >= rb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= val_i;
      r_q   <= '0;
      bit_q <= BitInit;
    end else if (busy_q) begin
      n_q   <= ge ? n_q - rb : n_q;
      r_q   <= ge ? (r_q >> 1) + bit_q : r_q >> 1;
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[RootW-1:0];

endmodule

// ===== hw/rtl/rpi_datapath.sv =====
// Datapath: configuration, body state, shared multiplier, divider and root unit, result beat.
// Depends on rpi_pkg, rpi_div and rpi_sqrt; driven by commands from rpi_ctrl.
module rpi_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rpi_pkg::rpi_in_t             in_data_i,
  input  logic                         cfg_valid_i,
  input  logic [rpi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpi_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rpi_pkg::rpi_out_t            out_data_o,
  input  rpi_pkg::rpi_cmd_t            cmd_i,
  output rpi_pkg::rpi_stat_t           stat_o
);
  import rpi_pkg::*;

  logic [RegW-1:0]          mass_q, limit_q, drag_q;
  logic                     grav_q, fric_q;
  logic [StepW-1:0]         dt_q;
  logic signed [FieldW-1:0] push_q [Lanes];
  logic signed [FieldW-1:0] vel_q [Lanes];
  logic signed [FieldW-1:0] pos_q [Lanes];
  logic signed [FieldW-1:0] vel_nxt [Lanes];
  logic signed [FieldW-1:0] pos_nxt [Lanes];
  logic signed [AccW-1:0]   acc_q [Lanes];
  logic [MagW-1:0]          mag_q [Lanes];
  logic [Lanes-1:0]         neg_q;
  logic                     shifted_q;
  logic [NumW-1:0]          prod_q;
  logic [SumW-1:0]          sum_q, mag_tot;
  logic [RootW-1:0]         vl_q, len_q;
  rpi_out_t                 out_q;
  logic                     out_valid_q;

  lane_t                    lane;
  logic signed [FieldW-1:0] v_sel, push_sel;
  logic [FieldW-1:0]        v_mag, push_mag;
  logic signed [AccW-1:0]   acc_sel, acc_abs, quot_acc;
  logic [MagW-1:0]          mag_sel;
  logic [DenW-1:0]          mass_eff;

  logic [DenW-1:0]  mul_a, mul_b;
  logic [NumW-1:0]  mul_p;
  logic             mul_en;
  logic             div_start, div_busy, div_done;
  logic [NumW-1:0]  div_num, div_quot;
  logic [DenW-1:0]  div_den;
  logic             sqrt_start, sqrt_busy, sqrt_done;
  logic [RootW-1:0] sqrt_root;
  logic             too_big;

  assign lane     = cmd_i.lane;
  assign v_sel    = vel_q[lane];
  assign v_mag    = v_sel[FieldW-1] ? FieldW'(-v_sel) : FieldW'(v_sel);
  assign push_sel = push_q[lane];
  assign push_mag = push_sel[FieldW-1] ? FieldW'(-push_sel) : FieldW'(push_sel);
  assign acc_sel  = acc_q[lane];
  assign acc_abs  = acc_sel[AccW-1] ? -acc_sel : acc_sel;
  assign mag_sel  = mag_q[lane];
  assign mass_eff = (mass_q == '0) ? DenW'(1) : {1'b0, mass_q};
  assign quot_acc = signed'({1'b0, div_quot[AccW-2:0]});
  assign mag_tot  = sum_q + {prod_q[SumW-33:0], 32'b0};

  // shared multiplier, operands chosen by the command
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      OP_MUL_VSQ: begin
        mul_a = v_mag;
        mul_b = v_mag;
      end
      OP_MUL_VDRAG: begin
        mul_a = v_mag;
        mul_b = {1'b0, drag_q};
      end
      OP_MUL_LO: begin
        mul_a = acc_abs[31:0];
        mul_b = DenW'(dt_q);
      end
      OP_MUL_HI: begin
        mul_a = DenW'(acc_abs[AccW-2:32]);
        mul_b = DenW'(dt_q);
      end
      OP_MUL_MSQ: begin
        mul_a = {1'b0, mag_sel[30:0]};
        mul_b = {1'b0, mag_sel[30:0]};
      end
      OP_MUL_MSL: begin
        mul_a = {1'b0, mag_sel[30:0]};
        mul_b = {1'b0, limit_q};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_start = 1'b1;
    div_num   = prod_q;
    div_den   = mass_eff;
    case (cmd_i.op)
      OP_DIV_PUSH:  div_num = {16'b0, push_mag, 16'b0};
      OP_DIV_FRIC1: div_den = vl_q;
      OP_DIV_FRIC2: div_num = {16'b0, div_quot[31:0], 16'b0};
      OP_DIV_CLAMP: div_den = len_q;
      default:      div_start = 1'b0;
    endcase
  end

  assign sqrt_start = cmd_i.op == OP_SQRT_START;

  rpi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  rpi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .val_i  (sum_q[NumW-1:0]),
    .busy_o (sqrt_busy),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      logic signed [FieldW:0] d;
      logic signed [FieldW:0] p;
      d = signed'({2'b0, mag_q[i][30:0]});
      if (neg_q[i]) begin
        d = -d;
      end
      vel_nxt[i] = sat33({vel_q[i][FieldW-1], vel_q[i]} + d);
      p = {pos_q[i][FieldW-1], pos_q[i]} + {vel_q[i][FieldW-1], vel_q[i]};
      pos_nxt[i] = sat33(p);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= MassReset;
      limit_q     <= LimitReset;
      drag_q      <= DragReset;
      grav_q      <= 1'b1;
      fric_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Lanes; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_BODY_MASS:   mass_q  <= cfg_data_i[RegW-1:0];
          CFG_SPEED_LIMIT: limit_q <= cfg_data_i[RegW-1:0];
          CFG_DRAG_COEF:   drag_q  <= cfg_data_i[RegW-1:0];
          CFG_GRAVITY_ON:  grav_q  <= cfg_data_i[0];
          CFG_FRICTION_ON: fric_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      // a new beat may replace one that leaves in the same cycle
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_UPD_V: begin
          for (int i = 0; i < Lanes; i++) begin
            vel_q[i] <= vel_nxt[i];
          end
        end
        OP_UPD_P: begin
          for (int i = 0; i < Lanes; i++) begin
            pos_q[i] <= pos_nxt[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_p;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        dt_q      <= in_data_i.step_time;
        push_q[0] <= in_data_i.push_x;
        push_q[1] <= in_data_i.push_y;
        push_q[2] <= in_data_i.push_z;
        shifted_q <= 1'b0;
      end
      OP_SET_ACC: acc_q[lane] <= push_sel[FieldW-1] ? -quot_acc : quot_acc;
      OP_GRAV: begin
        sum_q <= '0;
        if (grav_q) begin
          acc_q[1] <= acc_q[1] + GravityY;
        end
      end
      OP_ADD_PROD: sum_q <= sum_q + SumW'(prod_q);
      OP_SET_VL:   vl_q <= sqrt_root;
      // friction opposes the velocity
      OP_SUB_FRIC: acc_q[lane] <= v_sel[FieldW-1] ? acc_sel + quot_acc : acc_sel - quot_acc;
      OP_SUM_SET:  sum_q <= SumW'(prod_q);
      OP_SET_MAG: begin
        mag_q[lane] <= mag_tot[SumW-1:16];
        neg_q[lane] <= acc_sel[AccW-1];
      end
      OP_SHR: begin
        for (int i = 0; i < Lanes; i++) begin
          mag_q[i] <= mag_q[i] >> 1;
        end
        shifted_q <= 1'b1;
      end
      OP_CLR_SUM:  sum_q <= '0;
      OP_SET_LEN:  len_q <= sqrt_root;
      OP_SET_MAGQ: mag_q[lane] <= div_quot[MagW-1:0];
      OP_OUT: begin
        out_q.vel_x <= vel_q[0];
        out_q.vel_y <= vel_q[1];
        out_q.vel_z <= vel_q[2];
        out_q.pos_x <= pos_q[0];
        out_q.pos_y <= pos_q[1];
        out_q.pos_z <= pos_q[2];
      end
      default: ;
    endcase
  end

  assign too_big = |{mag_q[0][MagW-1:31], mag_q[1][MagW-1:31], mag_q[2][MagW-1:31]};

  assign stat_o.div_done    = div_done;
  assign stat_o.sqrt_done   = sqrt_done;
  assign stat_o.root_zero   = sqrt_root == '0;
  assign stat_o.friction_on = fric_q;
  assign stat_o.too_big     = too_big;
  assign stat_o.clamp       = shifted_q || (len_q > {1'b0, limit_q});
  assign stat_o.out_stall   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("root unit started while busy");

  a_clamp_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV_CLAMP) |-> (len_q != '0))
    else $error("clamp divides by zero length");

  a_upd_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_UPD_V) |-> !too_big)
    else $error("velocity change wider than 31 bits at update");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT) |-> !(out_valid_q && !out_ready_i))
    else $error("result beat overwritten");

endmodule

// ===== hw/rtl/rpi_ctrl.sv =====
// Sequencer for one integration step: issues datapath commands lane by lane.
// Depends on rpi_pkg for the command and status types.
module rpi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpi_pkg::rpi_stat_t stat_i,
  output rpi_pkg::rpi_cmd_t  cmd_o
);
  import rpi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PDIV, S_PDIV_W, S_GRAV,
    S_VSQ, S_VADD, S_VRT, S_VRT_W,
    S_FMUL, S_FDIV1, S_FDIV1_W, S_FDIV2, S_FDIV2_W,
    S_TLO, S_TLO_A, S_THI, S_THI_A, S_SHR,
    S_LSQ, S_LADD, S_LRT, S_LRT_W, S_CLAMP,
    S_CMUL, S_CDIV, S_CDIV_W, S_UPDV, S_UPDP, S_OUT
  } state_e;

  state_e state_q, state_d;
  lane_t  lane_q, lane_d;
  logic   last;

  assign last = lane_q == LaneLast;

  always_comb begin
    state_d    = state_q;
    lane_d     = lane_q;
    cmd_o.op   = OP_NOP;
    cmd_o.lane = lane_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          lane_d   = '0;
          state_d  = S_PDIV;
        end
      end
      S_PDIV: begin
        cmd_o.op = OP_DIV_PUSH;
        state_d  = S_PDIV_W;
      end
      S_PDIV_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_SET_ACC;
          lane_d   = last ? '0 : lane_q + 1'b1;
          state_d  = last ? S_GRAV : S_PDIV;
        end
      end
      S_GRAV: begin
        cmd_o.op = OP_GRAV;
        state_d  = stat_i.friction_on ? S_VSQ : S_TLO;
      end
      S_VSQ: begin
        cmd_o.op = OP_MUL_VSQ;
        state_d  = S_VADD;
      end
      S_VADD: begin
        cmd_o.op = OP_ADD_PROD;
        lane_d   = last ? '0 : lane_q + 1'b1;
        state_d  = last ? S_VRT : S_VSQ;
      end
      S_VRT: begin
        cmd_o.op = OP_SQRT_START;
        state_d  = S_VRT_W;
      end
      S_VRT_W: begin
        if (stat_i.sqrt_done) begin
          cmd_o.op = OP_SET_VL;
          // a body at rest feels no friction
          state_d  = stat_i.root_zero ? S_TLO : S_FMUL;
        end
      end
      S_FMUL: begin
        cmd_o.op = OP_MUL_VDRAG;
        state_d  = S_FDIV1;
      end
      S_FDIV1: begin
        cmd_o.op = OP_DIV_FRIC1;
        state_d  = S_FDIV1_W;
      end
      S_FDIV1_W: begin
        if (stat_i.div_done) begin
          state_d = S_FDIV2;
        end
      end
      S_FDIV2: begin
        cmd_o.op = OP_DIV_FRIC2;
        state_d  = S_FDIV2_W;
      end
      S_FDIV2_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_SUB_FRIC;
          lane_d   = last ? '0 : lane_q + 1'b1;
          state_d  = last ? S_TLO : S_FMUL;
        end
      end
      S_TLO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = S_TLO_A;
      end
      S_TLO_A: begin
        cmd_o.op = OP_SUM_SET;
        state_d  = S_THI;
      end
      S_THI: begin
        cmd_o.op = OP_MUL_HI;
        state_d  = S_THI_A;
      end
      S_THI_A: begin
        cmd_o.op = OP_SET_MAG;
        lane_d   = last ? '0 : lane_q + 1'b1;
        state_d  = last ? S_SHR : S_TLO;
      end
      S_SHR: begin
        // narrow the change until every component fits 31 bits
        if (stat_i.too_big) begin
          cmd_o.op = OP_SHR;
        end else begin
          cmd_o.op = OP_CLR_SUM;
          state_d  = S_LSQ;
        end
      end
      S_LSQ: begin
        cmd_o.op = OP_MUL_MSQ;
        state_d  = S_LADD;
      end
      S_LADD: begin
        cmd_o.op = OP_ADD_PROD;
        lane_d   = last ? '0 : lane_q + 1'b1;
        state_d  = last ? S_LRT : S_LSQ;
      end
      S_LRT: begin
        cmd_o.op = OP_SQRT_START;
        state_d  = S_LRT_W;
      end
      S_LRT_W: begin
        if (stat_i.sqrt_done) begin
          cmd_o.op = OP_SET_LEN;
          state_d  = S_CLAMP;
        end
      end
      S_CLAMP: begin
        state_d = stat_i.clamp ? S_CMUL : S_UPDV;
      end
      S_CMUL: begin
        cmd_o.op = OP_MUL_MSL;
        state_d  = S_CDIV;
      end
      S_CDIV: begin
        cmd_o.op = OP_DIV_CLAMP;
        state_d  = S_CDIV_W;
      end
      S_CDIV_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_SET_MAGQ;
          lane_d   = last ? '0 : lane_q + 1'b1;
          state_d  = last ? S_UPDV : S_CMUL;
        end
      end
      S_UPDV: begin
        cmd_o.op = OP_UPD_V;
        state_d  = S_UPDP;
      end
      S_UPDP: begin
        cmd_o.op = OP_UPD_P;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // hold until the previous result beat has gone
        if (!stat_i.out_stall) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// ===== hw/rtl/rigid_point_integrator.sv =====
// Explicit Euler step of one point body in signed Q16.16. Each input beat is one step; each
// step returns one result beat with the new velocity and position. A step is shortest with
// friction off and no clamp, and longest with friction on and the velocity change clamped.
// The step time is set by the shared divider, which yields one quotient bit per cycle
// and runs three to twelve times a step, and by the root unit. A finished result waits in
// the output register while the next step is accepted. Configuration is written on its own
// port, always ready; the user must write it only while no step runs, the block does not enforce it.
module rigid_point_integrator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rpi_pkg::rpi_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rpi_pkg::rpi_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rpi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpi_pkg::CfgDataW-1:0] cfg_data_i
);
  import rpi_pkg::*;

  rpi_cmd_t  cmd;
  rpi_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rpi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rpi_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

// ===== bench/rigid_point_integrator_test.sv =====
// Self-checking bench for rigid_point_integrator: drives step beats, predicts each result beat.
// Depends on rpi_pkg for the payload structs and register indexes, and on the top level RTL.
module rigid_point_integrator_test;
  import rpi_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd5;  // past the register list, must be ignored
  localparam longint GravityAcc = -642908;
  localparam longint OneQ = 65536;
  localparam longint unsigned Max31 = 64'h7FFF_FFFF;
  localparam int unsigned WatchLimit = 40000;
  localparam int unsigned SettleCycles = 1200;

  class step_scoreboard;
    longint unsigned mass, limit, drag;
    bit grav, fric;
    longint vel[3], pos[3];
    rpi_out_t awaited[$];
    int unsigned failures, checked;

    function new();
      mass = 65536; limit = 655360; drag = 0; grav = 1; fric = 0;
      foreach (vel[i]) begin
        vel[i] = 0;
        pos[i] = 0;
      end
      failures = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_BODY_MASS:   mass = data & Max31;
        CFG_SPEED_LIMIT: limit = data & Max31;
        CFG_DRAG_COEF:   drag = data & Max31;
        CFG_GRAVITY_ON:  grav = data[0];
        CFG_FRICTION_ON: fric = data[0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Advance the body by one step and queue the velocity and position it should report.
    function void note_step(rpi_in_t s);
      longint dt, m, d, q, r, f;
      longint acc[3];
      longint unsigned mag[3];
      bit neg[3];
      longint unsigned vl2, vl, len2, len, mm;
      int unsigned sh;
      rpi_out_t e;
      dt = longint'(s.step_time);
      m = (mass != 0) ? longint'(mass) : 1;
      acc[0] = (longint'(s.push_x) * OneQ) / m;
      acc[1] = (longint'(s.push_y) * OneQ) / m;
      acc[2] = (longint'(s.push_z) * OneQ) / m;
      if (grav) acc[1] += GravityAcc;
      if (fric) begin
        vl2 = 0;
        for (int i = 0; i < 3; i++) begin
          mm = (vel[i] < 0) ? longint'(-vel[i]) : vel[i];
          vl2 += mm * mm;
        end
        vl = root_floor(vl2);
        if (vl != 0) begin
          for (int i = 0; i < 3; i++) begin
            f = -((vel[i] * longint'(drag)) / longint'(vl));
            acc[i] += (f * OneQ) / m;
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        q = acc[i] / OneQ;
        r = acc[i] % OneQ;
        d = q * dt + (r * dt) / OneQ;
        neg[i] = d < 0;
        mag[i] = neg[i] ? longint'(-d) : d;
      end
      sh = 0;
      while ((mag[0] >> sh) > Max31 || (mag[1] >> sh) > Max31 || (mag[2] >> sh) > Max31) sh++;
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 += (mag[i] >> sh) * (mag[i] >> sh);
      len = root_floor(len2);
      if (sh > 0 || len > limit) begin
        for (int i = 0; i < 3; i++) mag[i] = ((mag[i] >> sh) * limit) / len;
      end
      for (int i = 0; i < 3; i++) begin
        d = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
        vel[i] = sat(vel[i] + d);
        pos[i] = sat(pos[i] + vel[i]);
      end
      e.vel_x = vel[0][31:0]; e.vel_y = vel[1][31:0]; e.vel_z = vel[2][31:0];
      e.pos_x = pos[0][31:0]; e.pos_y = pos[1][31:0]; e.pos_z = pos[2][31:0];
      awaited.push_back(e);
    endfunction

    function void check_result(rpi_out_t got);
      rpi_out_t e;
      logic signed [FieldW-1:0] ev[6], gv[6];
      string nm[6];
      if (awaited.size() == 0) begin
        $display("%0t: result beat with nothing awaited: %p", $time, got);
        failures++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      nm = '{"vel_x", "vel_y", "vel_z", "pos_x", "pos_y", "pos_z"};
      ev = '{e.vel_x, e.vel_y, e.vel_z, e.pos_x, e.pos_y, e.pos_z};
      gv = '{got.vel_x, got.vel_y, got.vel_z, got.pos_x, got.pos_y, got.pos_z};
      for (int i = 0; i < 6; i++) begin
        if (ev[i] !== gv[i]) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm[i], ev[i], gv[i]);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, cfg_valid, cfg_ready;
  logic out_ready = 1'b0;
  rpi_in_t in_data;
  rpi_out_t out_data;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  step_scoreboard board;
  int unsigned send_idle_pct, recv_idle_pct, steps_sent;
  int unsigned quiet_cycles = 0;

  rigid_point_integrator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, WatchLimit);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_step(rpi_in_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = s;
    do @(posedge clk); while (!in_ready);
    board.note_step(s);
    steps_sent++;
  endtask

  task automatic hold_off;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every awaited beat, then let the block settle before touching registers.
  task automatic drain;
    hold_off();
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic rpi_in_t make_step(logic [StepW-1:0] t, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
    rpi_in_t s;
    s.step_time = t;
    s.push_x = x;
    s.push_y = y;
    s.push_z = z;
    return s;
  endfunction

  function automatic logic [31:0] rand_push();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      2: return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [StepW-1:0] rand_time();
    case ($urandom_range(5))
      0: return StepW'($urandom);
      1: return StepW'($urandom_range(0, 1024));
      default: return StepW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] rand_reg();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 4194304);
      2: return $urandom_range(0, 2) ? 32'h7FFF_FFFF : 32'd0;
      default: return $urandom_range(1, 131072);
    endcase
  endfunction

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 27;
    recv_idle_pct = 60;
    steps_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, field extremes, zero and long steps.
    send_step(make_step(17'd0, 32'd0, 32'd0, 32'd0));
    send_step(make_step(17'd65536, 32'd0, 32'd0, 32'd0));
    send_step(make_step(17'h1FFFF, 32'd65536, 32'd0, 32'hFFFF_0000));
    send_step(make_step(17'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_step(make_step(17'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_step(make_step(17'd32768, 32'h0001_0000, 32'h000A_0000, 32'hFFFF_FFFF));
    drain();
    // Friction on a moving body, zero mass, tiny limit, then no limit at all.
    write_reg(CFG_FRICTION_ON, 32'h8000_0001);
    write_reg(CFG_DRAG_COEF, 32'h0003_0000);
    write_reg(CFG_BODY_MASS, 32'h8000_0000);
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    send_step(make_step(17'd65536, 32'h0002_0000, 32'h0, 32'h0001_0000));
    send_step(make_step(17'd16384, 32'h0, 32'h0, 32'h0));
    send_step(make_step(17'h1FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0));
    drain();
    write_reg(CFG_SPEED_LIMIT, 32'd0);
    write_reg(CFG_GRAVITY_ON, 32'd0);
    write_reg(CFG_BODY_MASS, 32'hFFFF_FFFF);
    send_step(make_step(17'd65536, 32'h7FFF_FFFF, 32'h0, 32'h0));
    send_step(make_step(17'd65536, 32'h0, 32'h0, 32'h0));
    drain();
    write_reg(CFG_SPEED_LIMIT, 32'h7FFF_FFFF);
    write_reg(CFG_DRAG_COEF, 32'h7FFF_FFFF);
    write_reg(CFG_BODY_MASS, 32'd1);
    send_step(make_step(17'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678));
    send_step(make_step(17'd100, 32'h0, 32'h0, 32'h0));
    send_step(make_step(17'd65536, 32'h0, 32'h0, 32'h0));
    drain();

    // Random phases: fresh settings each, idling pattern shifts across the run.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 27; recv_idle_pct = 60;
      end else if (ph < 7) begin
        send_idle_pct = 60; recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_reg(CFG_BODY_MASS, (ph == 0) ? 32'd1 : (ph == 1) ? 32'h7FFF_FFFF
                               : (ph == 2) ? 32'd65536 : rand_reg());
      write_reg(CFG_SPEED_LIMIT, (ph == 1) ? 32'd0 : (ph == 0) ? 32'h7FFF_FFFF : rand_reg());
      write_reg(CFG_DRAG_COEF, (ph == 0) ? 32'h7FFF_FFFF : rand_reg());
      write_reg(CFG_GRAVITY_ON, $urandom);
      write_reg(CFG_FRICTION_ON, (ph < 2) ? 32'd1 : $urandom);
      repeat (175) send_step(make_step(rand_time(), rand_push(), rand_push(), rand_push()));
      drain();
    end

    $display("Ran %0d steps over 14 register settings; %0d result beats compared.",
             steps_sent, board.checked);
    if (board.failures == 0 && board.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
